FILE: src/fcp_pkg.sv
`default_nettype none

package fcp_pkg;

    localparam int MAX_PARTITIONS  = 64;
    localparam int MAX_RESULTS     = 64;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam int SIZE_W      = 64;
    localparam int NUM_W       = 7;
    localparam int MIN_W       = 41;
    localparam int PART_IDX_W  = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CHUNK_CNT_W = $clog2(MAX_RESULTS);

    localparam logic [NUM_W-1:0]  RESET_NUM_PARTITIONS  = 7'd1;
    localparam logic [SIZE_W-1:0] RESET_PARTITION_BYTES = '0;
    localparam logic [MIN_W-1:0]  RESET_MIN_CHUNK_BYTES = MIN_W'(1024 * 1024);
    localparam logic [SIZE_W-1:0] ALL_ONES              = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_PARTITIONS  = 2'd0,
        REG_PARTITION_BYTES = 2'd1,
        REG_MIN_CHUNK_BYTES = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [SIZE_W-1:0]    data;
    } cfg_wr_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size_bytes;
        logic              is_splittable;
    } file_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic [NUM_W-1:0] parts_in_use(input logic [NUM_W-1:0] num);
        if (num == '0)
            return 7'd1;
        if (32'(num) > MAX_PARTITIONS)
            return NUM_W'(MAX_PARTITIONS);
        return num;
    endfunction

endpackage

`default_nettype wire

FILE: src/fcp_ifs.sv
`default_nettype none

interface fcp_file_if import fcp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] size_bytes;
    logic              is_splittable;

    modport source (output valid, output size_bytes, output is_splittable, input ready);
    modport sink   (input valid, input size_bytes, input is_splittable, output ready);
endinterface

interface fcp_chunk_if import fcp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PART_IDX_W-1:0] partition_index;
    logic [SIZE_W-1:0]     chunk_start;
    logic [SIZE_W-1:0]     chunk_end;
    logic                  last_chunk;

    modport source (output valid, output partition_index, output chunk_start,
                    output chunk_end, output last_chunk, input ready);
    modport sink   (input valid, input partition_index, input chunk_start,
                    input chunk_end, input last_chunk, output ready);
endinterface

`default_nettype wire

FILE: src/fcp_front.sv
`default_nettype none

module fcp_front import fcp_pkg::*;
(
    fcp_file_if.sink   files,
    input  q_status_t  q_stat,
    output logic       push,
    output file_item_t push_item
);

    // empty files produce no chunks; drop them here
    always_comb
    begin
        files.ready             = !q_stat.full;
        push                    = files.valid && !q_stat.full && (files.size_bytes != '0);
        push_item.size_bytes    = files.size_bytes;
        push_item.is_splittable = files.is_splittable;
    end

endmodule

`default_nettype wire

FILE: src/fcp_queue.sv
`default_nettype none

module fcp_queue import fcp_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  file_item_t push_item,
    input  logic       pop,
    output file_item_t head,
    output q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    file_item_t             mem_reg [DEPTH];
    logic       [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic       [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic       [LVL_W-1:0] level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        level_next   = level_reg + LVL_W'(push) - LVL_W'(pop);
        head         = mem_reg[rd_ptr_reg];
        status.empty = (level_reg == '0);
        status.full  = (level_reg == LVL_W'(DEPTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

FILE: src/fcp_back.sv
`default_nettype none

module fcp_back import fcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_wr_t     cfg,
    input  file_item_t  q_head,
    input  q_status_t   q_stat,
    output logic        q_pop,
    fcp_chunk_if.source chunks
);

    back_state_t             state_reg, state_next;
    logic [NUM_W-1:0]        num_parts_reg, num_parts_next;
    logic [SIZE_W-1:0]       part_bytes_reg, part_bytes_next;
    logic [MIN_W-1:0]        min_chunk_reg, min_chunk_next;
    logic [NUM_W-1:0]        part_reg, part_next;
    logic [SIZE_W-1:0]       left_reg, left_next;
    logic [SIZE_W-1:0]       rem_reg, rem_next;
    logic [SIZE_W-1:0]       pos_reg, pos_next;
    logic                    split_reg, split_next;
    logic [CHUNK_CNT_W-1:0]  count_reg, count_next;
    logic [SIZE_W-1:0]       alloc_reg, alloc_next;
    logic                    whole_reg, whole_next;
    logic [SIZE_W-1:0]       lmm_reg, lmm_next;
    logic                    lmm_ok_reg, lmm_ok_next;
    logic                    out_valid_reg, out_valid_next;
    logic [PART_IDX_W-1:0]   out_part_reg, out_part_next;
    logic [SIZE_W-1:0]       out_start_reg, out_start_next;
    logic [SIZE_W-1:0]       out_end_reg, out_end_next;
    logic                    out_last_reg, out_last_next;

    logic [NUM_W-1:0]  last_part;
    logic [NUM_W-1:0]  new_num;
    logic [SIZE_W-1:0] new_bytes;
    logic [SIZE_W:0]   left_plus_min;
    logic [SIZE_W:0]   left_minus_min;
    logic              whole;
    logic              out_free;
    logic [SIZE_W-1:0] end_sum;
    logic [SIZE_W-1:0] left_after;
    logic              keep_part;
    logic [NUM_W-1:0]  adv_part;
    logic [SIZE_W-1:0] adv_budget;

    always_comb
    begin
        last_part      = parts_in_use(num_parts_reg) - 7'd1;
        left_plus_min  = {1'b0, left_reg} + {{(SIZE_W + 1 - MIN_W){1'b0}}, min_chunk_reg};
        left_minus_min = {1'b0, left_reg} - {{(SIZE_W + 1 - MIN_W){1'b0}}, min_chunk_reg};
        whole          = !split_reg || ({1'b0, rem_reg} <= left_plus_min) ||
                         (count_reg == CHUNK_CNT_W'(MAX_RESULTS - 1));
        out_free       = !out_valid_reg || chunks.ready;
        end_sum        = pos_reg + alloc_reg;
        left_after     = left_reg - alloc_reg;
        keep_part      = lmm_ok_reg && (alloc_reg <= lmm_reg) && (left_after != '0);
        adv_part       = (part_reg < last_part) ? part_reg + 7'd1 : part_reg;
        adv_budget     = (({1'b0, part_reg} + 8'd1) >= {1'b0, last_part}) ? ALL_ONES
                                                                            : part_bytes_reg;

        state_next      = state_reg;
        num_parts_next  = num_parts_reg;
        part_bytes_next = part_bytes_reg;
        min_chunk_next  = min_chunk_reg;
        part_next       = part_reg;
        left_next       = left_reg;
        rem_next        = rem_reg;
        pos_next        = pos_reg;
        split_next      = split_reg;
        count_next      = count_reg;
        alloc_next      = alloc_reg;
        whole_next      = whole_reg;
        lmm_next        = lmm_reg;
        lmm_ok_next     = lmm_ok_reg;
        out_valid_next  = out_valid_reg && !chunks.ready;
        out_part_next   = out_part_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                alloc_next  = whole ? rem_reg : left_reg;
                whole_next  = whole;
                lmm_next    = left_minus_min[SIZE_W-1:0];
                lmm_ok_next = !left_minus_min[SIZE_W];
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_part_next  = part_reg[PART_IDX_W-1:0];
                    out_start_next = pos_reg;
                    out_end_next   = split_reg ? end_sum : ALL_ONES;
                    out_last_next  = whole_reg;
                    count_next     = count_reg + 1'b1;
                    rem_next       = rem_reg - alloc_reg;
                    pos_next       = end_sum;
                    if (keep_part)
                        left_next = left_after;
                    else
                    begin
                        part_next = adv_part;
                        left_next = adv_budget;
                    end
                    if (!whole_reg)
                        state_next = ST_DECIDE;
                    else if (!q_stat.empty)
                    begin
                        q_pop      = 1'b1;
                        state_next = ST_DECIDE;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // start of a new file
        if (q_pop)
        begin
            rem_next   = q_head.size_bytes;
            pos_next   = '0;
            split_next = q_head.is_splittable;
            count_next = '0;
        end

        // user writes only while idle (unenforced); count/size writes restart dealing
        new_num   = num_parts_reg;
        new_bytes = part_bytes_reg;
        if (cfg.we)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_NUM_PARTITIONS:
                begin
                    new_num        = cfg.data[NUM_W-1:0];
                    num_parts_next = new_num;
                    part_next      = '0;
                    left_next      = (parts_in_use(new_num) == 7'd1) ? ALL_ONES : new_bytes;
                end
                REG_PARTITION_BYTES:
                begin
                    new_bytes       = cfg.data;
                    part_bytes_next = new_bytes;
                    part_next       = '0;
                    left_next       = (parts_in_use(new_num) == 7'd1) ? ALL_ONES : new_bytes;
                end
                REG_MIN_CHUNK_BYTES:
                begin
                    min_chunk_next = cfg.data[MIN_W-1:0];
                end
                default:
                begin
                    min_chunk_next = min_chunk_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_parts_reg  <= RESET_NUM_PARTITIONS;
            part_bytes_reg <= RESET_PARTITION_BYTES;
            min_chunk_reg  <= RESET_MIN_CHUNK_BYTES;
            part_reg       <= '0;
            left_reg       <= ALL_ONES;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            num_parts_reg  <= num_parts_next;
            part_bytes_reg <= part_bytes_next;
            min_chunk_reg  <= min_chunk_next;
            part_reg       <= part_next;
            left_reg       <= left_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        pos_reg       <= pos_next;
        split_reg     <= split_next;
        alloc_reg     <= alloc_next;
        whole_reg     <= whole_next;
        lmm_reg       <= lmm_next;
        lmm_ok_reg    <= lmm_ok_next;
        out_part_reg  <= out_part_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        chunks.valid           = out_valid_reg;
        chunks.partition_index = out_part_reg;
        chunks.chunk_start     = out_start_reg;
        chunks.chunk_end       = out_end_reg;
        chunks.last_chunk      = out_last_reg;
    end

endmodule

`default_nettype wire

FILE: src/file_chunk_partitioner_unit.sv
`default_nettype none
// Channel  Dir  Payload
// files    in   size_bytes[63:0], is_splittable
// chunks   out  partition_index[5:0], chunk_start[63:0], chunk_end[63:0], last_chunk
// cfg      in   cfg_wr_en, cfg_index[1:0], cfg_wdata[63:0] (write only)
//
// Each chunk passes the back-end sequencer states decide, then emit; emit waits while the
// sink stalls the output register. A queued next file is popped in the last emit, else the
// idle state pops it first. Empty files are dropped by the front and never queued.
// Files wait in a QUEUE_DEPTH-entry queue, so the front accepts while chunks go out.
// The chunk output register lets the next chunk be decided while the sink stalls.
// Reset: partition 0, budget all ones, registers at defaults; no clearing pass.

module file_chunk_partitioner_unit import fcp_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_wdata,
    fcp_file_if.sink             files,
    fcp_chunk_if.source          chunks
);

    cfg_wr_t    cfg;
    q_status_t  q_stat;
    logic       q_push;
    logic       q_pop;
    file_item_t q_item;
    file_item_t q_head;

    always_comb
    begin
        cfg.we    = cfg_wr_en;
        cfg.index = cfg_index;
        cfg.data  = cfg_wdata;
    end

    fcp_front u_front
    (
        .files     (files),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_item (q_item)
    );

    fcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_stat)
    );

    fcp_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .q_head (q_head),
        .q_stat (q_stat),
        .q_pop  (q_pop),
        .chunks (chunks)
    );

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("request pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("request popped from empty queue");

    a_no_empty_file: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_item.size_bytes != '0))
        else $error("empty file queued");
`endif

endmodule

`default_nettype wire

FILE: verif/file_chunk_partitioner_unit_tb.sv
`default_nettype none

typedef struct packed {
    logic [fcp_pkg::PART_IDX_W-1:0] part;
    logic [fcp_pkg::SIZE_W-1:0]     start_off;
    logic [fcp_pkg::SIZE_W-1:0]     end_off;
    logic                           last_chunk;
} chunk_t;

class chunk_scoreboard;
    logic [fcp_pkg::NUM_W-1:0]  num_parts;
    logic [fcp_pkg::SIZE_W-1:0] part_bytes;
    logic [fcp_pkg::MIN_W-1:0]  min_bytes;
    int                         cur_part;
    logic [fcp_pkg::SIZE_W-1:0] budget_left;
    chunk_t                     expected_chunks[$];
    int unsigned                errors;

    function new();
        errors     = 0;
        num_parts  = fcp_pkg::RESET_NUM_PARTITIONS;
        part_bytes = fcp_pkg::RESET_PARTITION_BYTES;
        min_bytes  = fcp_pkg::RESET_MIN_CHUNK_BYTES;
        restart();
    endfunction

    function int used_parts();
        if (num_parts == '0)
            return 1;
        if (int'(num_parts) > fcp_pkg::MAX_PARTITIONS)
            return fcp_pkg::MAX_PARTITIONS;
        return int'(num_parts);
    endfunction

    function logic [fcp_pkg::SIZE_W-1:0] fresh_budget(int part);
        return (part + 1 >= used_parts()) ? fcp_pkg::ALL_ONES : part_bytes;
    endfunction

    function void restart();
        cur_part    = 0;
        budget_left = fresh_budget(0);
    endfunction

    function void apply_reg(logic [fcp_pkg::CFG_IDX_W-1:0] idx,
                            logic [fcp_pkg::SIZE_W-1:0] value);
        case (idx)
            fcp_pkg::REG_NUM_PARTITIONS:
            begin
                num_parts = value[fcp_pkg::NUM_W-1:0];
                restart();
            end
            fcp_pkg::REG_PARTITION_BYTES:
            begin
                part_bytes = value;
                restart();
            end
            fcp_pkg::REG_MIN_CHUNK_BYTES:
            begin
                min_bytes = value[fcp_pkg::MIN_W-1:0];
            end
            default:
            begin
            end
        endcase
    endfunction

    // Deals one file out over the partitions and queues its chunks.
    function void deal_file(logic [fcp_pkg::SIZE_W-1:0] file_bytes, logic split);
        logic [fcp_pkg::SIZE_W-1:0] remaining;
        logic [fcp_pkg::SIZE_W-1:0] pos;
        logic [fcp_pkg::SIZE_W-1:0] alloc;
        logic [fcp_pkg::SIZE_W-1:0] min_size;
        int                         last_part;
        int                         n;
        logic                       whole;
        chunk_t                     c;

        last_part = used_parts() - 1;
        if (cur_part > last_part)
            cur_part = last_part;
        min_size  = min_bytes;
        remaining = file_bytes;
        n         = 0;
        while (remaining != '0)
        begin
            pos   = file_bytes - remaining;
            whole = !split || remaining <= budget_left ||
                    remaining - budget_left <= min_size ||
                    n == fcp_pkg::MAX_RESULTS - 1;
            alloc = whole ? remaining : budget_left;

            c.part       = cur_part[fcp_pkg::PART_IDX_W-1:0];
            c.start_off  = pos;
            c.end_off    = split ? pos + alloc : fcp_pkg::ALL_ONES;
            c.last_chunk = (alloc == remaining);
            expected_chunks.insert(expected_chunks.size(), c);
            n++;

            // keep the partition open only if at least min_size stays behind
            if (alloc <= budget_left && min_size <= budget_left &&
                alloc <= budget_left - min_size && budget_left != alloc)
            begin
                budget_left -= alloc;
            end
            else
            begin
                if (cur_part < last_part)
                    cur_part++;
                budget_left = fresh_budget(cur_part);
            end
            remaining -= alloc;
        end
    endfunction

    task flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_chunk(chunk_t got);
        chunk_t want;

        if (expected_chunks.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected chunk part %0d start %0h end %0h last %0b",
                                    got.part, got.start_off, got.end_off, got.last_chunk));
            return;
        end
        want = expected_chunks.pop_front();
        if (got.part != want.part)
            flag_mismatch($sformatf("partition_index got %0d want %0d (start %0h)",
                                    got.part, want.part, want.start_off));
        if (got.start_off != want.start_off)
            flag_mismatch($sformatf("chunk_start got %0h want %0h",
                                    got.start_off, want.start_off));
        if (got.end_off != want.end_off)
            flag_mismatch($sformatf("chunk_end got %0h want %0h (start %0h)",
                                    got.end_off, want.end_off, want.start_off));
        if (got.last_chunk != want.last_chunk)
            flag_mismatch($sformatf("last_chunk got %0b want %0b (start %0h)",
                                    got.last_chunk, want.last_chunk, want.start_off));
    endtask
endclass

module file_chunk_partitioner_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcp_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 1_000_000;
    localparam int unsigned SETTLE_CYCLES    = 16;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_PHASES    = 6;
    localparam int unsigned FILES_PER_PHASE  = 22;

    // index 3 is not a register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_wdata;

    fcp_file_if  files_if ();
    fcp_chunk_if chunks_if ();

    file_chunk_partitioner_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .files     (files_if),
        .chunks    (chunks_if)
    );

    chunk_scoreboard sb = new();
    bit              sender_gaps;
    bit              hold_pending;
    int unsigned     cycle_cnt;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL file_chunk_partitioner_unit");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_file(input logic [SIZE_W-1:0] file_bytes, input logic split);
        int unsigned gap;

        gap = sender_gaps ? $urandom_range(0, 14) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            files_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        files_if.valid         <= 1'b1;
        files_if.size_bytes    <= file_bytes;
        files_if.is_splittable <= split;
        do @(posedge clk); while (files_if.ready !== 1'b1);
        sb.deal_file(file_bytes, split);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.apply_reg(idx, value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // empty files leave nothing to wait for, so allow extra settling time
    task automatic settle();
        @(negedge clk);
        files_if.valid <= 1'b0;
        while (sb.expected_chunks.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned stall;
        int unsigned calm_left;
        bit          calm;
        chunk_t      got;

        chunks_if.ready = 1'b0;
        calm_left = 0;
        calm      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (calm_left == 0)
            begin
                calm_left = $urandom_range(4, 40);
                calm      = ($urandom_range(0, 2) == 0);
            end
            calm_left--;
            if (hold_pending)
            begin
                stall        = LONG_HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            else
            begin
                stall = calm ? 0 : $urandom_range(0, 14);
            end
            @(negedge clk);
            if (stall != 0)
            begin
                chunks_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            chunks_if.ready <= 1'b1;
            do @(posedge clk); while (chunks_if.valid !== 1'b1);
            got.part       = chunks_if.partition_index;
            got.start_off  = chunks_if.chunk_start;
            got.end_off    = chunks_if.chunk_end;
            got.last_chunk = chunks_if.last_chunk;
            sb.check_chunk(got);
        end
    end

    initial
    begin
        int unsigned       phase;
        int unsigned       k;
        int unsigned       scale;
        logic [SIZE_W-1:0] mask;
        logic [SIZE_W-1:0] value;
        logic [SIZE_W-1:0] file_bytes;

        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_index              = REG_NUM_PARTITIONS;
        cfg_wdata              = '0;
        files_if.valid         = 1'b0;
        files_if.size_bytes    = '0;
        files_if.is_splittable = 1'b0;
        sender_gaps            = 1'b1;
        hold_pending           = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: one partition with an unlimited budget
        send_file(64'd0, 1'b1);
        send_file(64'd1, 1'b1);
        send_file(ALL_ONES, 1'b1);
        send_file(ALL_ONES, 1'b0);
        send_file(64'd12345, 1'b0);

        settle();
        write_reg(REG_NUM_PARTITIONS, 64'd4);
        write_reg(REG_PARTITION_BYTES, 64'd1000);
        write_reg(REG_MIN_CHUNK_BYTES, 64'd100);
        send_file(64'd500, 1'b1);
        send_file(64'd600, 1'b1);
        send_file(64'd2500, 1'b1);
        send_file(64'd300, 1'b0);
        send_file(64'd0, 1'b0);

        // zero budget: zero-length chunks up to the per-file chunk limit
        settle();
        write_reg(REG_NUM_PARTITIONS, 64'd64);
        write_reg(REG_PARTITION_BYTES, 64'd0);
        write_reg(REG_MIN_CHUNK_BYTES, 64'd0);
        send_file(64'd1000, 1'b1);
        send_file(64'd5, 1'b1);

        // budget used up exactly
        settle();
        write_reg(REG_NUM_PARTITIONS, 64'd2);
        write_reg(REG_PARTITION_BYTES, 64'd100);
        send_file(64'd100, 1'b1);
        send_file(64'd50, 1'b1);

        // count above the maximum, widest budget and minimum
        settle();
        write_reg(REG_NUM_PARTITIONS, 64'd127);
        write_reg(REG_PARTITION_BYTES, ALL_ONES);
        write_reg(REG_MIN_CHUNK_BYTES, ALL_ONES);
        send_file(ALL_ONES, 1'b1);
        send_file(64'h0000_0001_0000_0000, 1'b1);
        send_file(64'd7, 1'b0);

        settle();
        write_reg(REG_NUM_PARTITIONS, 64'd0);
        write_reg(REG_SPARE, ALL_ONES);
        write_reg(REG_MIN_CHUNK_BYTES, 64'h0000_0100_0000_0000);
        send_file(64'h8000_0000_0000_0000, 1'b1);
        send_file(64'd3, 1'b1);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            scale = $urandom_range(8, 48);
            mask  = (64'd1 << scale) - 64'd1;

            value = rand64();
            case ($urandom_range(0, 5))
                0:       value[NUM_W-1:0] = 7'd0;
                1:       value[NUM_W-1:0] = 7'd1;
                2:       value[NUM_W-1:0] = 7'd64;
                3:       value[NUM_W-1:0] = 7'($urandom_range(65, 127));
                default: value[NUM_W-1:0] = 7'($urandom_range(2, 64));
            endcase
            write_reg(REG_NUM_PARTITIONS, value);

            case ($urandom_range(0, 7))
                0:       value = '0;
                1:       value = ALL_ONES;
                default: value = rand64() & mask;
            endcase
            write_reg(REG_PARTITION_BYTES, value);

            case ($urandom_range(0, 5))
                0:       value = '0;
                1:       value = rand64();
                default: value = rand64() & (mask >> $urandom_range(1, 6));
            endcase
            write_reg(REG_MIN_CHUNK_BYTES, value);

            sender_gaps  = (phase % 3 != 1);
            hold_pending = (phase == 1);
            for (k = 0; k < FILES_PER_PHASE; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       file_bytes = '0;
                    1:       file_bytes = rand64();
                    2:       file_bytes = rand64() & 64'hFF;
                    default: file_bytes = rand64() & ((mask << 2) | 64'd3);
                endcase
                send_file(file_bytes, $urandom_range(0, 4) != 0);
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_chunks.size() == 0)
            $display("PASS file_chunk_partitioner_unit");
        else
            $display("FAIL file_chunk_partitioner_unit");
        $finish;
    end

endmodule

`default_nettype wire
